FILE: hw/rtl/uve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 value escaper package
// Token types shared by the front and back parts, and the table that turns
// one token into its escaped output bytes.
// ----------------------------------------------------------------------------
package uve_pkg;

  // One token stands for one output action decided by the front part.
  typedef enum logic [1:0] {
    TOK_RAW = 2'd0,  // byte of a valid multi-byte character, copied as is
    TOK_HEX = 2'd1,  // byte that could not be decoded, written as \xhh
    TOK_ESC = 2'd2   // single-byte character, escaped where needed
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  value;
  } tok_t;

  localparam int unsigned TokPerEntry = 4;

  // All tokens caused by one input word.
  typedef struct packed {
    tok_t [TokPerEntry-1:0] tok;
    logic [1:0]             last_idx;  // index of the final token
  } entry_t;

  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowU  = 8'h75;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] CtrlLim = 8'h20;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      hex_digit = ChZero + {4'b0, v};
    end else begin
      hex_digit = 8'h57 + {4'b0, v};  // 'a' minus ten
    end
  endfunction

  // Number of output bytes a token expands to.
  function automatic logic [2:0] tok_len(input tok_t t);
    tok_len = 3'd1;
    unique case (t.kind)
      TOK_RAW: tok_len = 3'd1;
      TOK_HEX: tok_len = 3'd4;
      TOK_ESC: begin
        if (t.value == ChEq || t.value == ChBsl || t.value == ChLf ||
            t.value == ChCr) begin
          tok_len = 3'd2;
        end else if (t.value < CtrlLim) begin
          tok_len = 3'd6;
        end else begin
          tok_len = 3'd1;
        end
      end
      default: tok_len = 3'd1;
    endcase
  endfunction

  // Output byte number k of a token.
  function automatic logic [7:0] tok_char(input tok_t t, input logic [2:0] k);
    tok_char = t.value;
    unique case (t.kind)
      TOK_RAW: tok_char = t.value;
      TOK_HEX: begin
        unique case (k)
          3'd0:    tok_char = ChBsl;
          3'd1:    tok_char = ChLowX;
          3'd2:    tok_char = hex_digit(t.value[7:4]);
          default: tok_char = hex_digit(t.value[3:0]);
        endcase
      end
      TOK_ESC: begin
        if (t.value == ChEq || t.value == ChBsl) begin
          tok_char = (k == 3'd0) ? ChBsl : t.value;
        end else if (t.value == ChLf) begin
          tok_char = (k == 3'd0) ? ChBsl : ChLowN;
        end else if (t.value == ChCr) begin
          tok_char = (k == 3'd0) ? ChBsl : ChLowR;
        end else if (t.value < CtrlLim) begin
          unique case (k)
            3'd0:    tok_char = ChBsl;
            3'd1:    tok_char = ChLowU;
            3'd2:    tok_char = ChZero;
            3'd3:    tok_char = ChZero;
            3'd4:    tok_char = hex_digit(t.value[7:4]);
            default: tok_char = hex_digit(t.value[3:0]);
          endcase
        end else begin
          tok_char = t.value;
        end
      end
      default: tok_char = t.value;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/uve_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one raw value byte per word.
// ----------------------------------------------------------------------------
interface uve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_value;

  modport source (output valid, output in_byte, output end_of_value, input ready);
  modport sink   (input valid, input in_byte, input end_of_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/uve_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one escaped output byte per word.
// ----------------------------------------------------------------------------
interface uve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/uve_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaper front part
// Accepts input words, keeps the held partial UTF-8 sequence and turns each
// word into a list of output tokens.
// ----------------------------------------------------------------------------
module uve_front import uve_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uve_in_if.sink    in_i,
  input  wire logic full_i,
  output logic      push_o,
  output entry_t    push_entry_o
);

  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic       accept;

  logic [7:0] buf_b [4];
  logic [2:0] n_bytes;
  logic [2:0] pos;
  logic [2:0] tcnt;
  logic [2:0] len;
  logic [2:0] avail;
  logic [7:0] b;
  logic [7:0] c;
  logic [20:0] cp;
  logic       brk;
  logic       bad;
  entry_t     ent;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      buf_b[k] = (2'(k) < pend_cnt_q) ? pend_q[k] : in_i.in_byte;
    end
    buf_b[3] = in_i.in_byte;
    n_bytes  = {1'b0, pend_cnt_q} + 3'd1;

    pos        = 3'd0;
    tcnt       = 3'd0;
    len        = 3'd0;
    avail      = 3'd0;
    b          = 8'h00;
    c          = 8'h00;
    cp         = '0;
    brk        = 1'b0;
    bad        = 1'b0;
    ent        = '0;
    pend_cnt_d = 2'd0;
    for (int q = 0; q < 3; q++) begin
      pend_d[q] = pend_q[q];
    end

    // Each pass consumes at least one byte, so four passes cover the buffer.
    for (int it = 0; it < 4; it++) begin
      if (pos < n_bytes) begin
        b = buf_b[pos[1:0]];
        if (!b[7]) begin
          ent.tok[tcnt[1:0]] = '{kind: TOK_ESC, value: b};
          tcnt = tcnt + 3'd1;
          pos  = pos + 3'd1;
        end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
          ent.tok[tcnt[1:0]] = '{kind: TOK_HEX, value: b};
          tcnt = tcnt + 3'd1;
          pos  = pos + 3'd1;
        end else begin
          if (b[7:5] == 3'b110) begin
            len = 3'd2;
            cp  = {16'b0, b[4:0]};
          end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
            cp  = {17'b0, b[3:0]};
          end else begin
            len = 3'd4;
            cp  = {18'b0, b[2:0]};
          end
          avail = n_bytes - pos;
          brk   = 1'b0;
          for (int j = 1; j < 4; j++) begin
            if (3'(j) < len && 3'(j) < avail && !brk) begin
              c = buf_b[2'(pos + 3'(j))];
              if (c[7:6] != 2'b10) begin
                brk = 1'b1;
              end else begin
                cp = {cp[14:0], c[5:0]};
              end
            end
          end
          bad = (len == 3'd2 && cp < 21'h80) || (len == 3'd3 && cp < 21'h800) ||
                (len == 3'd4 && cp < 21'h10000) || (cp > 21'h10FFFF) ||
                (cp[20:11] == 10'h01B);
          if (brk || (len > avail && in_i.end_of_value) ||
              (len <= avail && bad)) begin
            ent.tok[tcnt[1:0]] = '{kind: TOK_HEX, value: b};
            tcnt = tcnt + 3'd1;
            pos  = pos + 3'd1;
          end else if (len > avail) begin
            // Incomplete sequence: hold it for the next word.
            pend_cnt_d = avail[1:0];
            for (int q = 0; q < 3; q++) begin
              if (3'(q) < avail) begin
                pend_d[q] = buf_b[2'(pos + 3'(q))];
              end
            end
            pos = n_bytes;
          end else begin
            for (int j = 0; j < 4; j++) begin
              if (3'(j) < len) begin
                ent.tok[tcnt[1:0]] = '{kind: TOK_RAW, value: buf_b[2'(pos + 3'(j))]};
                tcnt = tcnt + 3'd1;
              end
            end
            pos = pos + len;
          end
        end
      end
    end
    ent.last_idx = 2'(tcnt - 3'd1);
  end

  assign push_o       = accept && (tcnt != 3'd0);
  assign push_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
    end else if (accept) begin
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int q = 0; q < 3; q++) begin
        pend_q[q] <= pend_d[q];
      end
    end
  end

  // A word that ends the value leaves nothing held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.end_of_value) |=> (pend_cnt_q == 2'd0))
    else $error("partial sequence held across end of value");

endmodule
`default_nettype wire

FILE: hw/rtl/uve_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaper token queue
// Short register queue of token lists between the front and back parts.
// ----------------------------------------------------------------------------
module uve_queue import uve_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      head_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [IdxW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

FILE: hw/rtl/uve_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaper back part
// Walks the head token list and writes one escaped byte per cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module uve_back import uve_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   entry_valid_i,
  input  wire entry_t entry_i,
  output logic        pop_o,
  uve_out_if.source   out_o
);

  logic [1:0] tok_idx_q, tok_idx_d;
  logic [2:0] byte_idx_q, byte_idx_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_out_q;
  tok_t       cur_tok;
  logic       tok_done;
  logic       entry_done;
  logic       advance;

  assign cur_tok    = entry_i.tok[tok_idx_q];
  assign tok_done   = (byte_idx_q == tok_len(cur_tok) - 3'd1);
  assign entry_done = tok_done && (tok_idx_q == entry_i.last_idx);
  assign advance    = entry_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o      = advance && entry_done;

  always_comb begin
    tok_idx_d  = tok_idx_q;
    byte_idx_d = byte_idx_q;
    if (advance) begin
      if (tok_done) begin
        byte_idx_d = 3'd0;
        tok_idx_d  = entry_done ? 2'd0 : tok_idx_q + 2'd1;
      end else begin
        byte_idx_d = byte_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_idx_q   <= 2'd0;
      byte_idx_q  <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      tok_idx_q  <= tok_idx_d;
      byte_idx_q <= byte_idx_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= tok_char(cur_tok, byte_idx_q);
      last_out_q <= entry_done;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last_out = last_out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_i |-> (tok_idx_q <= entry_i.last_idx))
    else $error("token index past the end of the list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !entry_valid_i |-> (tok_idx_q == 2'd0 && byte_idx_q == 3'd0))
    else $error("back part left mid-list without a list");

endmodule
`default_nettype wire

FILE: hw/rtl/utf8_value_escaper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 value escaper
// Escapes the bytes of a value string: valid UTF-8 passes through, special
// and control characters get backslash escapes, undecodable bytes become \xhh.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Fields                    Word
//   in_i      in    in_byte[7:0] end_of_value  one raw byte of the value
//   out_o     out   out_byte[7:0] last_out     one byte of the escaped text
//
// The front part takes one input word per cycle whenever the token queue has
// room, so while the queue has room the input side runs at one word per cycle.
// The back part writes one output byte per cycle while the output is not
// stalled; a word makes up to 18 output bytes, and the bytes per word set the
// sustained rate. Plain printable text makes one byte per word and so flows at
// one word per cycle when the output does not stall.
// An accepted word goes through the queue register, then the output register.
// Reset clears the held sequence count, the queue pointers and the output
// register valid; there is no clearing pass.
// A stall on the output holds the output register, then fills the queue, and
// only then drops in_i.ready.
//
module utf8_value_escaper_top import uve_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uve_in_if.sink    in_i,
  uve_out_if.source out_o
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // Decodes the held sequence plus the new byte into up to four tokens.
  uve_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decouples input acceptance from output stalls.
  uve_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (head_valid),
    .head_o       (head)
  );

  // Expands tokens into escaped bytes; last_out marks the final byte of a word.
  uve_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (head_valid),
    .entry_i       (head),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule
`default_nettype wire
